// ----- rtl/tte_pkg.sv -----
// Shared constants, types and helpers for the thrust to set point block.
`default_nettype none

package tte_pkg;

  // Field and datapath widths
  localparam int THRUST_WIDTH = 16;
  localparam int COEF_WIDTH   = 32;
  localparam int X_W          = THRUST_WIDTH - 1;
  localparam int X_FRAC       = 11;
  localparam int ACC_FRAC     = 24;
  localparam int ACC_W        = 48;
  localparam int MAG_W        = ACC_W - 1;
  localparam int SUM_W        = ACC_W + 1;
  localparam int LO_W         = 24;
  localparam int HI_W         = MAG_W - LO_W;
  localparam int PROD_W       = MAG_W + X_W;
  localparam int PSH_W        = PROD_W - X_FRAC;
  localparam int T_W          = MAG_W - ACC_FRAC;
  localparam int SP_W         = 8;

  // Coefficient list and register map
  localparam int NUM_COEF     = 7;
  localparam int HORNER_STEPS = NUM_COEF - 1;
  localparam int COEF_IDX_W   = $clog2(NUM_COEF);
  localparam int CFG_IDX_W    = 4;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_COEF_X6      = cfg_idx_t'(0);
  localparam cfg_idx_t REG_MIN_SETPOINT = cfg_idx_t'(NUM_COEF);

  localparam logic [MAG_W-1:0] ACC_MAG = '1;
  localparam logic [SP_W-1:0]  SP_MAX  = '1;
  localparam logic [SP_W-1:0]  MIN_SP_RESET = '0;

  // Coefficients from the sixth power down to the constant term, Q8.24
  localparam logic signed [COEF_WIDTH-1:0] COEF_RESET [NUM_COEF] = '{
    COEF_WIDTH'(14900),
    COEF_WIDTH'(-663388),
    COEF_WIDTH'(11254828),
    COEF_WIDTH'(-87431106),
    COEF_WIDTH'(273971937),
    COEF_WIDTH'(182099903),
    COEF_WIDTH'(51677181)
  };

  // Accumulator carried in sign/magnitude form between Horner steps
  typedef struct packed {
    logic             pos;   // thrust > 0
    logic [X_W-1:0]   x;     // thrust magnitude
    logic             neg;   // accumulator sign
    logic [MAG_W-1:0] mag;   // accumulator magnitude, saturated
  } tte_item_t;

  // Magnitude of a signed sum, saturated to the accumulator limit
  function automatic logic [MAG_W-1:0] sat_abs(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-1:0] a;
    a = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
    return (a > SUM_W'(ACC_MAG)) ? ACC_MAG : a[MAG_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tte_in_if.sv -----
// Input channel: one thrust sample per beat.
`default_nettype none

interface tte_in_if import tte_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [THRUST_WIDTH-1:0] thrust;

  modport source (output valid, output thrust, input ready);
  modport sink   (input valid, input thrust, output ready);
endinterface

`default_nettype wire

// ----- rtl/tte_out_if.sv -----
// Result channel: set point and clamp flag per beat.
`default_nettype none

interface tte_out_if import tte_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [SP_W-1:0] setpoint;
  logic            clamped;

  modport source (output valid, output setpoint, output clamped, input ready);
  modport sink   (input valid, input setpoint, input clamped, output ready);
endinterface

`default_nettype wire

// ----- rtl/thrust_to_esc_setpoint.sv -----
// Thrust to speed-controller set point: six-step pipelined Horner evaluation.
//
// Input channel in_bus carries one signed Q5.11 thrust per beat; result channel
// out_bus carries an 8-bit set point and a clamp flag, one result per input,
// in input order. Both use valid/ready; a beat moves when both are high.
// Thrust <= 0 gives the configured minimum set point. Otherwise a degree-6
// polynomial with Q8.24 coefficients is evaluated, truncated toward zero and
// clamped to 0..255 (clamp flag set when limited, and also at exactly 255).
// From input beat to result valid a beat passes one entry stage, three stages
// for each of the six Horner steps (split multiply, add, saturate) and the
// output register. Throughput is one beat per cycle unless out_bus stalls.
// Every stage has its own valid bit; when the receiver stalls, the output
// register holds and stages behind it keep filling bubbles before in_bus.ready
// drops, so nothing is lost or repeated.
// Registers are written through cfg_we/cfg_index/cfg_wdata: index 0..6 are
// the coefficients from x^6 down to the constant, 7 the minimum set point;
// other indexes are ignored. Write only while the pipeline is empty.
// Synchronous reset empties the pipeline and loads the default coefficients.
`default_nettype none

module thrust_to_esc_setpoint import tte_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [COEF_WIDTH-1:0] cfg_wdata,
  tte_in_if.sink                     in_bus,
  tte_out_if.source                  out_bus
);

  logic signed [COEF_WIDTH-1:0] coef_r [NUM_COEF];
  logic [SP_W-1:0]              min_sp_r;

  tte_item_t chain_item [HORNER_STEPS+1];
  logic      chain_vld  [HORNER_STEPS+1];
  logic      chain_rdy  [HORNER_STEPS+1];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_r[i] <= COEF_RESET[i];
      end
      min_sp_r <= MIN_SP_RESET;
    end else if (cfg_we) begin
      if (cfg_index < cfg_idx_t'(NUM_COEF)) begin
        coef_r[cfg_index[COEF_IDX_W-1:0]] <= cfg_wdata;
      end else if (cfg_index == REG_MIN_SETPOINT) begin
        min_sp_r <= cfg_wdata[SP_W-1:0];
      end
    end
  end

  // Entry: sign check and accumulator load
  tte_entry u_entry (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_bus.valid),
    .in_rdy   (in_bus.ready),
    .thrust   (in_bus.thrust),
    .coef     (coef_r[REG_COEF_X6[COEF_IDX_W-1:0]]),
    .out_vld  (chain_vld[0]),
    .out_rdy  (chain_rdy[0]),
    .out_item (chain_item[0])
  );

  // Horner steps, one per remaining coefficient
  for (genvar g = 0; g < HORNER_STEPS; g++) begin : g_step
    tte_horner_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (chain_vld[g]),
      .in_rdy   (chain_rdy[g]),
      .in_item  (chain_item[g]),
      .coef     (coef_r[g+1]),
      .out_vld  (chain_vld[g+1]),
      .out_rdy  (chain_rdy[g+1]),
      .out_item (chain_item[g+1])
    );
  end

  // Truncate, clamp and output register
  tte_finish u_finish (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_vld       (chain_vld[HORNER_STEPS]),
    .in_rdy       (chain_rdy[HORNER_STEPS]),
    .in_item      (chain_item[HORNER_STEPS]),
    .min_setpoint (min_sp_r),
    .out_bus      (out_bus)
  );

`ifndef ASSERT_OFF
  // An empty output register means the whole ready chain is open
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_bus.valid |-> in_bus.ready)
    else $error("input stalled while output register empty");

  // The clamp flag only accompanies a range limit
  a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.clamped) |->
      (out_bus.setpoint == '0 || out_bus.setpoint == SP_MAX))
    else $error("clamp flag with set point inside range");

  // Entry stage captures the thrust sign check of the accepted beat
  a_entry_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready) |=>
      (chain_vld[0] && chain_item[0].pos ==
        $past(!in_bus.thrust[THRUST_WIDTH-1] && in_bus.thrust[X_W-1:0] != '0)))
    else $error("entry stage sign flag mismatch");
`endif

endmodule

`default_nettype wire

// ----- rtl/tte_entry.sv -----
// Entry stage: thrust sign check and accumulator load from the top coefficient.
`default_nettype none

module tte_entry import tte_pkg::*; (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_vld,
  output logic                                in_rdy,
  input  wire logic signed [THRUST_WIDTH-1:0] thrust,
  input  wire logic signed [COEF_WIDTH-1:0]   coef,
  output logic                                out_vld,
  input  wire logic                           out_rdy,
  output tte_item_t                           out_item
);

  logic      vld_r;
  tte_item_t item_r;
  tte_item_t item_nxt;

  assign in_rdy   = !vld_r || out_rdy;
  assign out_vld  = vld_r;
  assign out_item = item_r;

  // Positive thrust check and sign/magnitude of the leading coefficient
  always_comb begin
    item_nxt.pos = !thrust[THRUST_WIDTH-1] && (thrust[X_W-1:0] != '0);
    item_nxt.x   = thrust[X_W-1:0];
    item_nxt.neg = coef[COEF_WIDTH-1];
    item_nxt.mag = sat_abs(SUM_W'(coef));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tte_horner_step.sv -----
// One Horner step in three stages: split multiply, combine and add, saturate.
`default_nettype none

module tte_horner_step import tte_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_vld,
  output logic                              in_rdy,
  input  wire tte_item_t                    in_item,
  input  wire logic signed [COEF_WIDTH-1:0] coef,
  output logic                              out_vld,
  input  wire logic                         out_rdy,
  output tte_item_t                         out_item
);

  localparam int PL_W = LO_W + X_W;
  localparam int PH_W = HI_W + X_W;

  logic s1_vld_r, s2_vld_r, s3_vld_r;
  logic s1_rdy, s2_rdy, s3_rdy;

  tte_item_t          s1_item_r, s2_item_r, s3_item_r, s3_item_nxt;
  logic [PL_W-1:0]    pp_lo_r, pp_lo_nxt;
  logic [PH_W-1:0]    pp_hi_r, pp_hi_nxt;
  logic [PROD_W-1:0]  prod;
  logic [PSH_W-1:0]   p_raw;
  logic [MAG_W-1:0]   p_sat;
  logic signed [SUM_W-1:0] p_ext, coef_ext, sum_r, sum_nxt;

  // Per-stage ready: a stage moves when empty or when its successor moves
  assign s3_rdy  = !s3_vld_r || out_rdy;
  assign s2_rdy  = !s2_vld_r || s3_rdy;
  assign s1_rdy  = !s1_vld_r || s2_rdy;
  assign in_rdy  = s1_rdy;
  assign out_vld = s3_vld_r;
  assign out_item = s3_item_r;

  // Stage 1: magnitude split in two halves, each times x
  always_comb begin
    pp_lo_nxt = PL_W'(in_item.mag[LO_W-1:0]) * PL_W'(in_item.x);
    pp_hi_nxt = PH_W'(in_item.mag[MAG_W-1:LO_W]) * PH_W'(in_item.x);
  end

  // Stage 2: full product, drop fraction bits, saturate, signed add of coefficient
  always_comb begin
    prod     = (PROD_W'(pp_hi_r) << LO_W) + PROD_W'(pp_lo_r);
    p_raw    = prod[PROD_W-1:X_FRAC];
    p_sat    = (p_raw > PSH_W'(ACC_MAG)) ? ACC_MAG : p_raw[MAG_W-1:0];
    p_ext    = SUM_W'(p_sat);
    coef_ext = SUM_W'(coef);
    sum_nxt  = s1_item_r.neg ? (coef_ext - p_ext) : (coef_ext + p_ext);
  end

  // Stage 3: back to sign/magnitude with the accumulator clamp
  always_comb begin
    s3_item_nxt     = s2_item_r;
    s3_item_nxt.neg = sum_r[SUM_W-1];
    s3_item_nxt.mag = sat_abs(sum_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_vld_r <= in_vld;
      if (s2_rdy) s2_vld_r <= s1_vld_r;
      if (s3_rdy) s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_vld) begin
      s1_item_r <= in_item;
      pp_lo_r   <= pp_lo_nxt;
      pp_hi_r   <= pp_hi_nxt;
    end
    if (s2_rdy && s1_vld_r) begin
      s2_item_r <= s1_item_r;
      sum_r     <= sum_nxt;
    end
    if (s3_rdy && s2_vld_r) begin
      s3_item_r <= s3_item_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tte_finish.sv -----
// Output stage: truncate to integer, clamp to 0..255 and drive the result channel.
`default_nettype none

module tte_finish import tte_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_vld,
  output logic                 in_rdy,
  input  wire tte_item_t       in_item,
  input  wire logic [SP_W-1:0] min_setpoint,
  tte_out_if.source            out_bus
);

  logic            vld_r;
  logic [SP_W-1:0] setpoint_r, setpoint_nxt;
  logic            clamped_r, clamped_nxt;
  logic [T_W-1:0]  t_mag;

  assign in_rdy           = !vld_r || out_bus.ready;
  assign out_bus.valid    = vld_r;
  assign out_bus.setpoint = setpoint_r;
  assign out_bus.clamped  = clamped_r;

  // Integer part toward zero, then the range check
  always_comb begin
    t_mag = in_item.mag[MAG_W-1:ACC_FRAC];
    if (!in_item.pos) begin
      setpoint_nxt = min_setpoint;
      clamped_nxt  = 1'b0;
    end else if (in_item.neg) begin
      setpoint_nxt = '0;
      clamped_nxt  = (t_mag != '0);
    end else if (t_mag >= T_W'(SP_MAX)) begin
      setpoint_nxt = SP_MAX;
      clamped_nxt  = 1'b1;
    end else begin
      setpoint_nxt = t_mag[SP_W-1:0];
      clamped_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      setpoint_r <= setpoint_nxt;
      clamped_r  <= clamped_nxt;
    end
  end

endmodule

`default_nettype wire
